// ===== rtl/core/ler_pkg.sv =====
// Shared constants and types for the line equation rasterizer.
package ler_pkg;

    localparam int COORD_BITS = 6;
    localparam int CLASS_BITS = 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CLASS_BITS-1:0] t_class;

    localparam t_class CLS_VERT      = 3'd0;
    localparam t_class CLS_HORZ      = 3'd1;
    localparam t_class CLS_DIAG_UP   = 3'd2;
    localparam t_class CLS_DIAG_DOWN = 3'd3;
    localparam t_class CLS_SHALLOW   = 3'd4;
    localparam t_class CLS_STEEP     = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture endpoints of an accepted transaction
        logic setup;     // order endpoints, classify, load the stepper
        logic step;      // advance to the next pixel
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;      // current pixel is the final one of the line
    } t_dp_status;

endpackage

// ===== rtl/core/ler_if.sv =====
// Handshake channels: line endpoints in, pixels out.
interface ler_line_if import ler_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord x_start;
    t_coord y_start;
    t_coord x_end;
    t_coord y_end;

    modport source (output valid, output x_start, output y_start,
                    output x_end, output y_end, input ready);
    modport sink   (input valid, input x_start, input y_start,
                    input x_end, input y_end, output ready);
endinterface

interface ler_pix_if import ler_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    t_class line_class;
    logic   last;

    modport source (output valid, output pixel_x, output pixel_y,
                    output line_class, output last, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input line_class, input last, output ready);
endinterface

// ===== rtl/core/ler_dp.sv =====
// Datapath: endpoint ordering, classification and exact incremental stepping.
module ler_dp import ler_pkg::*; (
    input  logic       i_clk,
    input  t_dp_cmd    i_cmd,
    input  t_coord     i_x_start,
    input  t_coord     i_y_start,
    input  t_coord     i_x_end,
    input  t_coord     i_y_end,
    output t_coord     o_pixel_x,
    output t_coord     o_pixel_y,
    output t_class     o_line_class,
    output t_dp_status o_status
);

    localparam int DW = COORD_BITS + 1;  // signed delta
    localparam int RW = COORD_BITS + 2;  // remainder plus increment

    // captured endpoints
    t_coord r_xa, r_ya, r_xb, r_yb;

    // stepper state
    t_coord               r_px, n_px;
    t_coord               r_py, n_py;
    t_class               r_cls;
    logic                 r_xmaj;
    logic                 r_yneg;
    logic signed [RW-1:0] r_inc;
    t_coord               r_den;
    logic signed [RW-1:0] r_rem, n_rem;
    t_coord               r_cnt;
    t_coord               r_n;

    // set-up logic
    logic                 w_swap;
    t_coord               w_x1, w_y1, w_x2, w_y2;
    t_coord               w_dx;
    logic signed [DW-1:0] w_dy;
    t_coord               w_ady;
    logic                 w_xmaj;
    t_class               w_cls;

    // step logic
    logic signed [RW-1:0] w_sum;
    logic signed [RW-1:0] w_den_s;
    logic                 w_up;
    logic                 w_dn;

    always_comb begin
        w_swap = (r_xa > r_xb) || ((r_xa == r_xb) && (r_ya > r_yb));
        w_x1   = w_swap ? r_xb : r_xa;
        w_y1   = w_swap ? r_yb : r_ya;
        w_x2   = w_swap ? r_xa : r_xb;
        w_y2   = w_swap ? r_ya : r_yb;
        w_dx   = w_x2 - w_x1;
        w_dy   = $signed({1'b0, w_y2}) - $signed({1'b0, w_y1});
        w_ady  = w_dy[DW-1] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
        // diagonal and horizontal lines run along x like shallow ones
        w_xmaj = (w_dx != '0) && (w_ady <= w_dx);
        if (w_dx == '0) begin
            w_cls = CLS_VERT;
        end else if (w_dy == '0) begin
            w_cls = CLS_HORZ;
        end else if (w_ady == w_dx) begin
            w_cls = w_dy[DW-1] ? CLS_DIAG_DOWN : CLS_DIAG_UP;
        end else if (w_ady < w_dx) begin
            w_cls = CLS_SHALLOW;
        end else begin
            w_cls = CLS_STEEP;
        end
    end

    // remainder stays in [0, den): one correction per step keeps the floor exact
    always_comb begin
        w_den_s = $signed({2'b00, r_den});
        w_sum   = r_rem + r_inc;
        w_up    = 1'b0;
        w_dn    = 1'b0;
        if (w_sum >= w_den_s) begin
            n_rem = w_sum - w_den_s;
            w_up  = 1'b1;
        end else if (w_sum < 0) begin
            n_rem = w_sum + w_den_s;
            w_dn  = 1'b1;
        end else begin
            n_rem = w_sum;
        end
        if (r_xmaj) begin
            n_px = r_px + 1'b1;
            n_py = w_up ? r_py + 1'b1 : (w_dn ? r_py - 1'b1 : r_py);
        end else begin
            n_py = r_yneg ? r_py - 1'b1 : r_py + 1'b1;
            n_px = w_up ? r_px + 1'b1 : r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_xa <= i_x_start;
            r_ya <= i_y_start;
            r_xb <= i_x_end;
            r_yb <= i_y_end;
        end
        if (i_cmd.setup) begin
            r_px   <= w_x1;
            r_py   <= w_y1;
            r_cls  <= w_cls;
            r_xmaj <= w_xmaj;
            r_yneg <= w_dy[DW-1];
            r_inc  <= w_xmaj ? RW'(w_dy) : $signed({2'b00, w_dx});
            r_den  <= w_xmaj ? w_dx : w_ady;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_n    <= w_xmaj ? w_dx : w_ady;
        end else if (i_cmd.step) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_line_class  = r_cls;
    assign o_status.last = (r_cnt == r_n);

endmodule

// ===== rtl/core/ler_ctrl.sv =====
// Controller: sequences capture, set-up and per-pixel output transactions.
module ler_ctrl import ler_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0] r_state, n_state;
    logic       w_in_acc;
    logic       w_out_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_RUN);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    always_comb begin
        o_cmd.load_in = w_in_acc;
        o_cmd.setup   = (r_state == ST_SETUP);
        o_cmd.step    = w_out_acc && !i_status.last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_out_acc && i_status.last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pixels advance only on a completed output transaction
    a_step_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (o_out_valid && i_out_ready && !i_status.last))
        else $error("step without output transaction");

    // the final pixel frees the input side
    a_last_frees_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && i_status.last) |=> o_in_ready)
        else $error("input not ready after final pixel");

    // a taken line passes through the set-up state before its first pixel is offered
    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##2 o_out_valid)
        else $error("first pixel not presented");

endmodule

// ===== rtl/core/line_equation_rasterizer.sv =====
// Line equation rasterizer top level: controller plus datapath.
// Takes one line per input transaction and emits its pixels, ordered from the
// endpoint with the smaller x (smaller y for vertical lines), one output
// transaction per pixel, each tagged with the line class; last marks the final
// pixel. A line has n+1 pixels (n = larger of |dx| and |dy|). With an
// always-ready sink, the block takes the endpoints, then orders and classifies
// them, then gives one pixel per cycle from the stepping accumulator, which
// forms the exact floored coordinate without a divider. The next line is taken
// in the cycle after the final pixel is delivered.
module line_equation_rasterizer import ler_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ler_line_if.sink   i_line,
    ler_pix_if.source  o_pix
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_coord     w_px;
    t_coord     w_py;
    t_class     w_cls;

    ler_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ler_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_x_start    (i_line.x_start),
        .i_y_start    (i_line.y_start),
        .i_x_end      (i_line.x_end),
        .i_y_end      (i_line.y_end),
        .o_pixel_x    (w_px),
        .o_pixel_y    (w_py),
        .o_line_class (w_cls),
        .o_status     (w_status)
    );

    assign o_pix.pixel_x    = w_px;
    assign o_pix.pixel_y    = w_py;
    assign o_pix.line_class = w_cls;
    assign o_pix.last       = w_status.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the line equation rasterizer: endpoint lines in, pixels checked.
module tb_top;
    import ler_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_class cls;
        logic   last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ler_line_if line_ch ();
    ler_pix_if  pix_ch ();

    line_equation_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_ch),
        .o_pix   (pix_ch)
    );

    t_pixel pending_pixels[$];
    int     fail_count  = 0;
    int     cycle_count = 0;
    bit     src_gaps    = 1'b0;
    bit     sink_stalls = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** line_equation_rasterizer: FAILED **");
            $finish;
        end
    end

    // random back-pressure on the pixel channel
    always @(posedge i_clk) begin
        pix_ch.ready <= !(sink_stalls && $urandom_range(99) < 28);
    end

    // floored quotient, divisor nonzero
    function automatic int floor_quot(int num, int den);
        int q;
        q = num / den;
        if ((num % den != 0) && ((num < 0) != (den < 0)))
            q = q - 1;
        return q;
    endfunction

    // expand one line into the pixels it should produce
    function automatic void predict_pixels(t_coord xs, t_coord ys, t_coord xe, t_coord ye);
        int     ax, ay, bx, by, dx, dy, ady, n, sy, px, py;
        t_class cls;
        t_pixel pix;
        if (xs > xe || (xs == xe && ys > ye)) begin
            ax = int'(xe); ay = int'(ye); bx = int'(xs); by = int'(ys);
        end else begin
            ax = int'(xs); ay = int'(ys); bx = int'(xe); by = int'(ye);
        end
        dx  = bx - ax;
        dy  = by - ay;
        ady = (dy < 0) ? -dy : dy;
        sy  = (dy < 0) ? -1 : 1;
        if (dx == 0) begin
            cls = CLS_VERT;
            n   = dy;
        end else if (dy == 0) begin
            cls = CLS_HORZ;
            n   = dx;
        end else if (ady == dx) begin
            cls = (dy > 0) ? CLS_DIAG_UP : CLS_DIAG_DOWN;
            n   = dx;
        end else if (ady < dx) begin
            cls = CLS_SHALLOW;
            n   = dx;
        end else begin
            cls = CLS_STEEP;
            n   = ady;
        end
        for (int i = 0; i <= n; i++) begin
            case (cls)
                CLS_VERT: begin
                    px = ax;     py = ay + i;
                end
                CLS_HORZ: begin
                    px = ax + i; py = ay;
                end
                CLS_SHALLOW: begin
                    px = ax + i; py = ay + floor_quot(dy * i, dx);
                end
                CLS_STEEP: begin
                    py = ay + sy * i;
                    px = ax + floor_quot(sy * i * dx, dy);
                end
                default: begin
                    px = ax + i; py = ay + sy * i;
                end
            endcase
            pix.x    = t_coord'(px);
            pix.y    = t_coord'(py);
            pix.cls  = cls;
            pix.last = (i == n);
            pending_pixels.push_back(pix);
        end
    endfunction

    // compare every accepted pixel with the oldest pending one
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", pix_ch.pixel_x, pix_ch.pixel_y);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (pix_ch.pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, actual %0d", want.x, pix_ch.pixel_x);
                    fail_count++;
                end
                if (pix_ch.pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, actual %0d", want.y, pix_ch.pixel_y);
                    fail_count++;
                end
                if (pix_ch.line_class !== want.cls) begin
                    $error("line_class: expected %0d, actual %0d",
                           want.cls, pix_ch.line_class);
                    fail_count++;
                end
                if (pix_ch.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, pix_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // valid is left high after a transaction so back-to-back lines need no toggle
    task automatic send_line(input t_coord xs, input t_coord ys,
                             input t_coord xe, input t_coord ye);
        while (src_gaps && $urandom_range(99) < 28) begin
            line_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_ch.valid   <= 1'b1;
        line_ch.x_start <= xs;
        line_ch.y_start <= ys;
        line_ch.x_end   <= xe;
        line_ch.y_end   <= ye;
        @(posedge i_clk);
        while (!line_ch.ready)
            @(posedge i_clk);
        predict_pixels(xs, ys, xe, ye);
    endtask

    task automatic send_random_line();
        t_coord xs, ys, xe, ye, tmp;
        int     len;
        xs = t_coord'($urandom_range(63));
        ys = t_coord'($urandom_range(63));
        xe = t_coord'($urandom_range(63));
        ye = t_coord'($urandom_range(63));
        case ($urandom_range(7))
            0: xe = xs;
            1: ye = ys;
            2, 3: begin
                len = int'($urandom_range(63));
                xs  = t_coord'($urandom_range(63 - len));
                xe  = t_coord'(int'(xs) + len);
                ys  = t_coord'($urandom_range(63 - len));
                ye  = t_coord'(int'(ys) + len);
                if ($urandom_range(1)) begin
                    tmp = ys; ys = ye; ye = tmp;
                end
                if ($urandom_range(1)) begin
                    tmp = xs; xs = xe; xe = tmp;
                    tmp = ys; ys = ye; ye = tmp;
                end
            end
            4: begin
                // short lines near the start point
                xe = xs + t_coord'($urandom_range(3)) - 2'd2;
                ye = ys + t_coord'($urandom_range(3)) - 2'd2;
            end
            default: ;
        endcase
        send_line(xs, ys, xe, ye);
    endtask

    task automatic test_corner_lines();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_line(6'd0,  6'd0,  6'd0,  6'd0);    // single point at origin
        send_line(6'd63, 6'd63, 6'd63, 6'd63);   // single point at far corner
        send_line(6'd5,  6'd10, 6'd5,  6'd50);   // vertical, upward
        send_line(6'd5,  6'd50, 6'd5,  6'd10);   // vertical, given top first
        send_line(6'd63, 6'd0,  6'd63, 6'd63);   // full-height vertical
        send_line(6'd0,  6'd0,  6'd63, 6'd0);    // full-width horizontal
        send_line(6'd63, 6'd7,  6'd0,  6'd7);    // horizontal, given right first
        send_line(6'd0,  6'd0,  6'd63, 6'd63);   // diagonal rising
        send_line(6'd0,  6'd63, 6'd63, 6'd0);    // diagonal falling
        send_line(6'd63, 6'd0,  6'd0,  6'd63);   // falling, given right first
        send_line(6'd10, 6'd20, 6'd11, 6'd21);   // two-pixel diagonal
        send_line(6'd0,  6'd0,  6'd63, 6'd20);   // shallow rising
        send_line(6'd0,  6'd40, 6'd50, 6'd3);    // shallow falling, floors below
        send_line(6'd50, 6'd3,  6'd0,  6'd40);   // same line reversed
        send_line(6'd0,  6'd0,  6'd63, 6'd62);   // nearly diagonal, shallow
        send_line(6'd3,  6'd0,  6'd10, 6'd63);   // steep rising
        send_line(6'd10, 6'd63, 6'd12, 6'd0);    // steep falling
        send_line(6'd40, 6'd2,  6'd30, 6'd60);   // steep falling, swapped order
        send_line(6'd0,  6'd1,  6'd1,  6'd63);   // steep, one column step
        send_line(6'd62, 6'd63, 6'd63, 6'd0);    // steep falling at right edge
        send_line(6'd20, 6'd20, 6'd21, 6'd22);   // short steep
    endtask

    task automatic test_random_lines_with_stalls(input int count);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        repeat (count) send_random_line();
    endtask

    task automatic test_back_to_back_lines(input int count);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (count) send_random_line();
    endtask

    task automatic drain_pixels();
        line_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        line_ch.valid   <= 1'b0;
        line_ch.x_start <= '0;
        line_ch.y_start <= '0;
        line_ch.x_end   <= '0;
        line_ch.y_end   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_lines();
        test_random_lines_with_stalls(150);
        test_back_to_back_lines(40);
        drain_pixels();

        if (fail_count == 0)
            $display("** line_equation_rasterizer: PASSED **");
        else
            $display("** line_equation_rasterizer: FAILED **");
        $finish;
    end

endmodule
